// ----- hw/rtl/tps_pkg.sv -----
// Package for the touch pad bisection scanner.
// Sizes, codes and the command/status structs shared by the controller,
// the datapath and the top level. Depends on nothing.
`default_nettype none

package tps_pkg;

	localparam int NUM_PADS   = 32;
	localparam int NUM_HANDS  = 2;
	localparam int MAX_ROUNDS = 4;
	localparam int MAX_RES    = 8;

	localparam int PAD_W = $clog2(NUM_PADS);
	localparam int RND_W = $clog2(MAX_ROUNDS + 1);
	localparam int RES_W = $clog2(MAX_RES + 1);
	localparam int ENT   = 64;
	localparam int ENT_W = 6;

	localparam logic [31:0] PAD_BITS  = 32'hFFFF_FFFF >> (32 - NUM_PADS);
	localparam logic [1:0]  HAND_BITS = 2'((1 << NUM_HANDS) - 1);

	localparam logic [1:0] REG_PAD_EN  = 2'd0;
	localparam logic [1:0] REG_HAND_EN = 2'd1;
	localparam logic [1:0] REG_REL     = 2'd2;
	localparam logic [1:0] REG_LOCK    = 2'd3;

	typedef enum logic [2:0] {
		ST_SCAN  = 3'd0,
		ST_NONE  = 3'd1,
		ST_NOISE = 3'd2,
		ST_DONE  = 3'd3,
		ST_GHOST = 3'd4
	} status_t;

	typedef enum logic [6:0] {
		PH_HI      = 7'b0000001,
		PH_LO      = 7'b0000010,
		PH_ENTRY   = 7'b0000100,
		PH_TEST    = 7'b0001000,
		PH_HALF    = 7'b0010000,
		PH_CONFIRM = 7'b0100000,
		PH_EXIT    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic load;
		logic step;
		logic half;
		logic walk;
		logic emit_next;
	} cmd_t;

	typedef struct packed {
		logic need_half;
		logic need_walk;
		logic half_last;
		logic walk_done;
		logic emit_last;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tps_ctrl.sv -----
// Controller of the touch pad bisection scanner.
// Sequences load, scan step, serial halving, table walk and result emission.
// Depends on tps_pkg.
`default_nettype none

module tps_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire tps_pkg::sts_t sts,
	output tps_pkg::cmd_t      cmd
);
	import tps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_STEP  = 5'b00010,
		S_HALVE = 5'b00100,
		S_WALK  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				priority if (sts.need_half) state_d = S_HALVE;
				else if (sts.need_walk)     state_d = S_WALK;
				else                        state_d = S_EMIT;
			end
			S_HALVE: begin
				cmd.half = 1'b1;
				if (sts.half_last) state_d = S_EMIT;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (!out_stall) begin
					cmd.emit_next = 1'b1;
					if (sts.emit_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_EMIT);

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is shown");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !sts.emit_last |=> out_valid)
		else $error("results dropped before the last one");

endmodule

`default_nettype wire

// ----- hw/rtl/tps_dp.sv -----
// Datapath of the touch pad bisection scanner.
// Scan state, config registers, serial halver, release/lockout tables and
// hit list. Depends on tps_pkg; driven by tps_ctrl commands.
`default_nettype none

module tps_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    wrist_sense,
	input  wire logic [47:0]   now_us,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_index,
	input  wire logic [31:0]   wr_data,
	input  wire tps_pkg::cmd_t cmd,
	output tps_pkg::sts_t      sts,
	output logic [31:0]        drive_mask,
	output logic [2:0]         scan_status,
	output logic               hit_valid,
	output logic [4:0]         hit_pad,
	output logic               hit_hand,
	output logic [47:0]        hit_time_us,
	output logic               last
);
	import tps_pkg::*;

	logic [31:0] pad_en_q;
	logic [1:0]  hand_en_q;
	logic [7:0]  rel_scans_q;
	logic [19:0] lockout_q;

	logic [1:0]  sense_q;
	logic [47:0] now_q;

	phase_t           phase_q;
	logic [1:0]       active_q;
	logic [47:0]      hit_time_q;
	logic [31:0]      search_q;
	logic [1:0][31:0] found_q;
	logic [RND_W-1:0] round_q;
	logic             cur_q;
	logic [31:0]      drive_q;
	status_t          status_q;

	logic [31:0] hm_q;
	logic [4:0]  hn_q;
	logic [4:0]  hk_q;
	logic [PAD_W-1:0] hidx_q;

	logic             wact_q;
	logic             wi_h_q;
	logic [PAD_W-1:0] wi_p_q;
	logic             s1_v;
	logic             s1_h;
	logic [PAD_W-1:0] s1_p;
	logic             s1_last;
	logic [7:0]       rc_rd_s1;
	logic [47:0]      lt_rd_s1;

	logic [7:0]  rc_mem [ENT];
	logic [47:0] lt_mem [ENT];
	logic [ENT-1:0] rcv_q;
	logic [ENT-1:0] ltv_q;
	logic [7:0]     rel_dflt_q;

	logic [RES_W-1:0] n_q;
	logic             any_q;
	logic [2:0]       e_q;
	logic [5:0]       hl_q [MAX_RES];

	// step logic
	logic [31:0]      all;
	logic             bit_s;
	phase_t           n_phase;
	logic [1:0]       n_active;
	logic [47:0]      n_hit;
	logic [31:0]      n_search;
	logic [1:0][31:0] n_found;
	logic [RND_W-1:0] n_round;
	logic             n_cur;
	logic [31:0]      n_drive;
	status_t          n_status;
	logic             bis, seek_en, seek_keep, rel_all, walk_go, need_half;
	logic [1:0]       seek_from;
	logic [5:0]       cnt;
	logic             picked;
	logic             pick_h;
	logic [1:0]       act;

	assign all   = pad_en_q & PAD_BITS;
	assign bit_s = sense_q[cur_q];

	always_comb begin
		n_phase   = phase_q;
		n_active  = active_q;
		n_hit     = hit_time_q;
		n_search  = search_q;
		n_found   = found_q;
		n_round   = round_q;
		n_cur     = cur_q;
		n_drive   = drive_q;
		n_status  = ST_SCAN;
		bis       = 1'b0;
		seek_en   = 1'b0;
		seek_keep = 1'b0;
		seek_from = 2'd0;
		rel_all   = 1'b0;
		walk_go   = 1'b0;
		need_half = 1'b0;
		picked    = 1'b0;
		pick_h    = 1'b0;
		cnt       = 6'd0;
		act       = active_q & ~sense_q & hand_en_q & HAND_BITS;
		unique case (phase_q)
			PH_HI: begin
				n_active = sense_q;
				n_drive  = '0;
				n_phase  = PH_LO;
			end
			PH_LO: begin
				if (act == 2'b00) begin
					rel_all  = 1'b1;
					n_active = 2'b00;
					n_status = ST_NONE;
					n_drive  = all;
					n_phase  = PH_HI;
				end else begin
					n_active = act;
					n_hit    = now_q;
					n_drive  = '0;
					n_phase  = PH_ENTRY;
				end
			end
			PH_ENTRY: begin
				if ((sense_q & active_q) != 2'b00) begin
					n_status = ST_NOISE;
					n_drive  = all;
					n_phase  = PH_HI;
				end else begin
					n_found = '0;
					seek_en = 1'b1;
				end
			end
			PH_TEST: begin
				if (!bit_s) begin
					seek_en   = 1'b1;
					seek_from = {1'b0, cur_q} + 2'd1;
				end else begin
					bis = 1'b1;
				end
			end
			PH_HALF: begin
				n_search = bit_s ? drive_q : (search_q & ~drive_q);
				bis      = 1'b1;
			end
			PH_CONFIRM: begin
				seek_en = 1'b1;
				if (!bit_s) begin
					seek_from = {1'b0, cur_q} + 2'd1;
				end else begin
					n_found[cur_q] = found_q[cur_q] | search_q;
					n_round        = round_q + 1'b1;
					if (n_round >= RND_W'(MAX_ROUNDS)) begin
						seek_from = {1'b0, cur_q} + 2'd1;
					end else begin
						seek_from = {1'b0, cur_q};
						seek_keep = 1'b1;
					end
				end
			end
			PH_EXIT: begin
				n_drive = all;
				n_phase = PH_HI;
				if ((sense_q & active_q) != 2'b00) n_status = ST_NOISE;
				else                               walk_go  = 1'b1;
			end
			default: begin
				n_drive = all;
				n_phase = PH_HI;
			end
		endcase

		if (bis) begin
			cnt = 6'($countones(n_search));
			priority if (cnt > 6'd1) begin
				need_half = 1'b1;
				n_drive   = '0;
				n_phase   = PH_HALF;
			end else if (cnt == 6'd0) begin
				seek_en   = 1'b1;
				seek_from = {1'b0, cur_q} + 2'd1;
			end else begin
				n_drive = n_search;
				n_phase = PH_CONFIRM;
			end
		end

		if (seek_en) begin
			for (int h = 0; h < NUM_HANDS; h++) begin
				if (!picked && 2'(h) >= seek_from && active_q[h] &&
				    (all & ~n_found[h]) != 32'd0) begin
					picked = 1'b1;
					pick_h = 1'(h);
				end
			end
			if (picked) begin
				n_cur    = pick_h;
				n_search = all & ~n_found[pick_h];
				n_drive  = n_search;
				n_phase  = PH_TEST;
				if (!(seek_keep && {1'b0, pick_h} == seek_from)) n_round = '0;
			end else begin
				n_drive = '0;
				n_phase = PH_EXIT;
			end
		end
	end

	// table walk, stage 1 compute
	logic [ENT_W-1:0] raddr, waddr;
	logic [7:0]  rc_cur, rc_wd;
	logic [47:0] lt_cur;
	logic [48:0] diff;
	logic        fnd, rel, arm, qual, rc_we, lt_we, w_last;

	assign raddr  = {wi_h_q, 5'(wi_p_q)};
	assign waddr  = {s1_h, 5'(s1_p)};
	assign w_last = (wi_h_q == 1'(NUM_HANDS - 1)) && (wi_p_q == PAD_W'(NUM_PADS - 1));
	assign rc_cur = rcv_q[waddr] ? rc_rd_s1 : rel_dflt_q;
	assign lt_cur = ltv_q[waddr] ? lt_rd_s1 : 48'd0;
	assign fnd    = found_q[s1_h][s1_p];
	assign diff   = {1'b0, hit_time_q} - {1'b0, lt_cur};
	assign arm    = !diff[48] && (diff[47:0] >= 48'(lockout_q));
	assign rel    = rc_cur >= rel_scans_q;
	assign qual   = s1_v && fnd && rel && arm && (n_q < RES_W'(MAX_RES));
	assign rc_we  = s1_v && (fnd || rc_cur != 8'hFF);
	assign rc_wd  = fnd ? 8'd0 : rc_cur + 8'd1;
	assign lt_we  = qual;

	always_ff @(posedge clk) begin
		if (rc_we) rc_mem[waddr] <= rc_wd;
		if (lt_we) lt_mem[waddr] <= hit_time_q;
		if (cmd.walk && wact_q) begin
			rc_rd_s1 <= rc_mem[raddr];
			lt_rd_s1 <= lt_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sense_q <= wrist_sense;
			now_q   <= now_us;
		end
		if (qual) hl_q[n_q[2:0]] <= {s1_h, 5'(s1_p)};
		if (cmd.walk && wact_q) begin
			s1_h    <= wi_h_q;
			s1_p    <= wi_p_q;
			s1_last <= w_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_en_q    <= 32'h1FFF_FFFF;
			hand_en_q   <= 2'd3;
			rel_scans_q <= 8'd3;
			lockout_q   <= 20'd20000;
			phase_q     <= PH_HI;
			active_q    <= '0;
			hit_time_q  <= '0;
			search_q    <= '0;
			found_q     <= '0;
			round_q     <= '0;
			cur_q       <= 1'b0;
			drive_q     <= '0;
			status_q    <= ST_SCAN;
			hm_q        <= '0;
			hn_q        <= '0;
			hk_q        <= '0;
			hidx_q      <= '0;
			wact_q      <= 1'b0;
			wi_h_q      <= 1'b0;
			wi_p_q      <= '0;
			s1_v        <= 1'b0;
			rcv_q       <= '0;
			ltv_q       <= '0;
			rel_dflt_q  <= 8'hFF;
			n_q         <= '0;
			any_q       <= 1'b0;
			e_q         <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_PAD_EN:  pad_en_q    <= wr_data;
					REG_HAND_EN: hand_en_q   <= wr_data[1:0];
					REG_REL:     rel_scans_q <= wr_data[7:0];
					REG_LOCK:    lockout_q   <= wr_data[19:0];
					default:     ;
				endcase
			end
			if (cmd.step) begin
				phase_q    <= n_phase;
				active_q   <= n_active;
				hit_time_q <= n_hit;
				search_q   <= n_search;
				found_q    <= n_found;
				round_q    <= n_round;
				cur_q      <= n_cur;
				drive_q    <= n_drive;
				status_q   <= n_status;
				n_q        <= '0;
				any_q      <= 1'b0;
				e_q        <= '0;
				if (rel_all) begin
					rcv_q      <= '0;
					rel_dflt_q <= rel_scans_q;
				end
				if (need_half) begin
					hm_q   <= n_search;
					hn_q   <= cnt[5:1];
					hk_q   <= '0;
					hidx_q <= '0;
				end
				if (walk_go) begin
					wact_q <= 1'b1;
					wi_h_q <= 1'b0;
					wi_p_q <= '0;
				end
			end
			// take the lowest half of the candidate bits, one bit a cycle
			if (cmd.half) begin
				if (hm_q[hidx_q] && hk_q < hn_q) begin
					drive_q[hidx_q] <= 1'b1;
					hk_q            <= hk_q + 5'd1;
				end
				hidx_q <= hidx_q + 1'b1;
			end
			if (cmd.walk) begin
				s1_v <= wact_q;
				if (wact_q) begin
					if (w_last) begin
						wact_q <= 1'b0;
					end else if (wi_p_q == PAD_W'(NUM_PADS - 1)) begin
						wi_p_q <= '0;
						wi_h_q <= 1'b1;
					end else begin
						wi_p_q <= wi_p_q + 1'b1;
					end
				end
				if (rc_we) rcv_q[waddr] <= 1'b1;
				if (lt_we) ltv_q[waddr] <= 1'b1;
				if (qual)  n_q <= n_q + 1'b1;
				if (s1_v && fnd) any_q <= 1'b1;
				if (s1_v && s1_last) status_q <= (any_q || fnd) ? ST_DONE : ST_GHOST;
			end else begin
				s1_v <= 1'b0;
			end
			if (cmd.emit_next && !sts.emit_last) e_q <= e_q + 3'd1;
		end
	end

	assign sts.need_half = need_half;
	assign sts.need_walk = walk_go;
	assign sts.half_last = (hidx_q == PAD_W'(NUM_PADS - 1));
	assign sts.walk_done = s1_v && s1_last;
	assign sts.emit_last = (n_q == '0) || ({1'b0, e_q} == n_q - 1'b1);

	assign drive_mask  = drive_q;
	assign scan_status = status_q;
	assign hit_valid   = (n_q != '0);
	assign hit_pad     = hit_valid ? hl_q[e_q][4:0] : 5'd0;
	assign hit_hand    = hit_valid ? hl_q[e_q][5] : 1'b0;
	assign hit_time_us = hit_valid ? hit_time_q : 48'd0;
	assign last        = sts.emit_last;

endmodule

`default_nettype wire

// ----- hw/rtl/touch_pad_bisection_scanner.sv -----
// Touch pad scanner: each item carries the wrist levels sampled after the
// previous drive mask settled and gives the next drive mask, a status and any
// hit events. An ordinary item is accepted, takes a scan step and gives a result.
// A bisection halving step adds a pass of the one-bit-a-cycle halver over the
// pads. The exit check adds a walk over the 64-entry release and lockout
// tables through one read port. A completed scan with hits then gives one
// result per recorded hit (up to MAX_RES), one per cycle while out_stall is low.
`default_nettype none

module touch_pad_bisection_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  wrist_sense,
	input  wire logic [47:0] now_us,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      drive_mask,
	output logic [2:0]       scan_status,
	output logic             hit_valid,
	output logic [4:0]       hit_pad,
	output logic             hit_hand,
	output logic [47:0]      hit_time_us,
	output logic             last,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [31:0] wr_data
);
	import tps_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.wrist_sense (wrist_sense),
		.now_us      (now_us),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.drive_mask  (drive_mask),
		.scan_status (scan_status),
		.hit_valid   (hit_valid),
		.hit_pad     (hit_pad),
		.hit_hand    (hit_hand),
		.hit_time_us (hit_time_us),
		.last        (last)
	);

endmodule

`default_nettype wire
